>>> sv/gsd_pkg.sv
// Shared types, codes and constants for the Gauss-Seidel diffusion grid.
// No dependencies; the engine, the top level and the testbench import this package.
package gsd_pkg;

    localparam int DEF_MAX_SIDE = 64;
    localparam int DEF_SWEEPS   = 11;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 40;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] REPLY_ACK  = 2'd0;
    localparam logic [1:0] REPLY_RUN  = 2'd1;
    localparam logic [1:0] REPLY_DATA = 2'd2;

    localparam logic [1:0] REG_GRID_SIZE      = 2'd0;
    localparam logic [1:0] REG_BOUNDARY_MODE  = 2'd1;
    localparam logic [1:0] REG_DIFFUSION_RATE = 2'd2;
    localparam logic [1:0] REG_TIME_STEP      = 2'd3;

    localparam logic [1:0] BND_NEG_COL = 2'd1;
    localparam logic [1:0] BND_NEG_ROW = 2'd2;

    localparam logic [6:0]  RST_GRID_SIZE = 7'd64;
    localparam logic [28:0] A_MAX         = 29'h1FFF_FFFF;
    localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN         = 32'h8000_0000;

    typedef struct packed {
        logic [6:0]  grid_size;
        logic [1:0]  boundary_mode;
        logic [30:0] diffusion_rate;
        logic [30:0] time_step;
    } cfg_t;

endpackage

>>> sv/gsd_ram.sv
// Simple dual-port synchronous RAM holding one 32-bit grid.
// One write port and one read port with registered read data; no package needed.
module gsd_ram #(
    parameter int DEPTH = 4356,
    parameter int AW    = 13
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/gsd_div.sv
// Restoring divider, one quotient bit per cycle, 33-bit quotient.
// Flags overflow when the quotient does not fit 33 bits; uses no package.
module gsd_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [32:0] quotient,
    output logic        overflow
);

    logic [31:0] rem_reg;
    logic [32:0] sh_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic        ovf_reg;
    logic [32:0] trial;
    logic        ge;
    logic [32:0] diff;

    assign trial = {rem_reg, sh_reg[32]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                dvs_reg <= divisor;
                if ({1'b0, dividend[63:33]} >= divisor) begin
                    ovf_reg  <= 1'b1;
                    done_reg <= 1'b1;
                end else begin
                    ovf_reg  <= 1'b0;
                    done_reg <= 1'b0;
                    rem_reg  <= {1'b0, dividend[63:33]};
                    sh_reg   <= dividend[32:0];
                    cnt_reg  <= 6'd33;
                    run_reg  <= 1'b1;
                end
            end else if (run_reg) begin
                rem_reg  <= ge ? diff[31:0] : trial[31:0];
                sh_reg   <= {sh_reg[31:0], ge};
                cnt_reg  <= cnt_reg - 6'd1;
                run_reg  <= (cnt_reg != 6'd1);
                done_reg <= (cnt_reg == 6'd1);
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;
    assign overflow = ovf_reg;

endmodule

>>> sv/gsd_engine.sv
// Run sequencer: computes the coefficient, does the Gauss-Seidel sweeps
// cell by cell through the grid memories, then fixes borders and corners.
// Depends on gsd_pkg and gsd_div.
module gsd_engine #(
    parameter int MAX_SIDE = 64,
    parameter int SWEEPS   = 11,
    parameter int AW       = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  gsd_pkg::cfg_t cfg,
    output logic          busy,
    output logic          done,
    output logic          sat,
    output logic          res_we,
    output logic [AW-1:0] res_waddr,
    output logic [31:0]   res_wdata,
    output logic [AW-1:0] res_raddr,
    input  logic [31:0]   res_rdata,
    output logic [AW-1:0] src_raddr,
    input  logic [31:0]   src_rdata
);
    import gsd_pkg::*;

    localparam int SPAN = MAX_SIDE + 2;
    localparam int CW   = $clog2(SPAN);
    localparam int XW   = (CW > 7) ? CW : 7;
    localparam int KW   = $clog2(SWEEPS + 1);
    localparam int UW   = 46 + CW;
    localparam int PW   = 29 + CW;

    localparam logic [3:0] E_IDLE = 4'd0;
    localparam logic [3:0] E_A1   = 4'd1;
    localparam logic [3:0] E_A2   = 4'd2;
    localparam logic [3:0] E_A3   = 4'd3;
    localparam logic [3:0] E_A4   = 4'd4;
    localparam logic [3:0] E_RD   = 4'd5;
    localparam logic [3:0] E_MUL  = 4'd6;
    localparam logic [3:0] E_NUM  = 4'd7;
    localparam logic [3:0] E_DIV  = 4'd8;
    localparam logic [3:0] E_BRD  = 4'd9;
    localparam logic [3:0] E_BWR  = 4'd10;
    localparam logic [3:0] E_CRD1 = 4'd11;
    localparam logic [3:0] E_CRD2 = 4'd12;
    localparam logic [3:0] E_CWR  = 4'd13;
    localparam logic [3:0] E_DONE = 4'd14;

    logic [3:0]         state_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [KW-1:0]      k_reg;
    logic [2:0]         cnt_reg;
    logic [1:0]         side_reg;
    logic               sat_reg;
    logic [61:0]        ab_reg;
    logic [UW-1:0]      u_reg;
    logic [PW-1:0]      p_reg;
    logic [28:0]        a_reg;
    logic signed [33:0] sum_reg;
    logic [31:0]        src_reg;
    logic signed [63:0] prod_reg;
    logic               neg_reg;
    logic [31:0]        hold_reg;

    logic [CW-1:0]      n_w;
    logic [CW-1:0]      one_c;
    logic [CW-1:0]      np1;
    logic signed [29:0] a_s;
    logic [63:0]        num;
    logic [63:0]        mag;
    logic [31:0]        den;
    logic [63:0]        div_dividend;
    logic               div_done;
    logic [32:0]        div_q;
    logic               div_ovf;
    logic [31:0]        wr_value;
    logic               wr_sat;
    logic               edge_neg;
    logic [31:0]        edge_val;
    logic               edge_sat;
    logic [32:0]        pair_sum;
    logic [CW-1:0]      rd_col;
    logic [CW-1:0]      rd_row;
    logic [CW-1:0]      wr_col;
    logic [CW-1:0]      wr_row;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                                 input logic [CW-1:0] r);
        return AW'(c) * AW'(SPAN) + AW'(r);
    endfunction

    always_comb begin
        if (cfg.grid_size == 7'd0) begin
            n_w = CW'(1);
        end else if (XW'(cfg.grid_size) > XW'(MAX_SIDE)) begin
            n_w = CW'(MAX_SIDE);
        end else begin
            n_w = CW'(cfg.grid_size);
        end
    end

    assign one_c = CW'(1);
    assign np1   = n_reg + one_c;
    assign a_s   = {1'b0, a_reg};
    assign num   = {{16{src_reg[31]}}, src_reg, 16'h0000} + prod_reg;
    assign mag   = num[63] ? (64'd0 - num) : num;
    assign den   = 32'h0001_0000 + {1'b0, a_reg, 2'b00};
    assign div_dividend = mag + {33'd0, den[31:1]};

    always_comb begin
        if (neg_reg) begin
            wr_sat   = div_ovf || div_q[32] || (div_q[31] && (div_q[30:0] != 31'd0));
            wr_value = wr_sat ? Q_MIN : (32'd0 - div_q[31:0]);
        end else begin
            wr_sat   = div_ovf || div_q[32] || div_q[31];
            wr_value = wr_sat ? Q_MAX : div_q[31:0];
        end
    end

    assign edge_neg = side_reg[1] ? (cfg.boundary_mode == BND_NEG_ROW)
                                  : (cfg.boundary_mode == BND_NEG_COL);
    assign edge_sat = edge_neg && (res_rdata == Q_MIN);
    assign edge_val = edge_sat ? Q_MAX : (edge_neg ? (32'd0 - res_rdata) : res_rdata);
    assign pair_sum = {hold_reg[31], hold_reg} + {res_rdata[31], res_rdata};

    always_comb begin
        rd_col = i_reg;
        rd_row = j_reg;
        wr_col = i_reg;
        wr_row = j_reg;
        res_we = 1'b0;
        res_wdata = wr_value;
        unique case (state_reg)
            E_RD: begin
                unique case (cnt_reg[1:0])
                    2'd0: rd_col = i_reg - one_c;
                    2'd1: rd_col = i_reg + one_c;
                    2'd2: rd_row = j_reg - one_c;
                    2'd3: rd_row = j_reg + one_c;
                endcase
            end
            E_DIV: begin
                res_we = div_done;
            end
            E_BRD, E_BWR: begin
                unique case (side_reg)
                    2'd0: begin
                        rd_col = one_c;   rd_row = i_reg;
                        wr_col = '0;      wr_row = i_reg;
                    end
                    2'd1: begin
                        rd_col = n_reg;   rd_row = i_reg;
                        wr_col = np1;     wr_row = i_reg;
                    end
                    2'd2: begin
                        rd_col = i_reg;   rd_row = one_c;
                        wr_col = i_reg;   wr_row = '0;
                    end
                    2'd3: begin
                        rd_col = i_reg;   rd_row = n_reg;
                        wr_col = i_reg;   wr_row = np1;
                    end
                endcase
                res_we    = (state_reg == E_BWR);
                res_wdata = edge_val;
            end
            E_CRD1, E_CRD2, E_CWR: begin
                unique case (side_reg)
                    2'd0: begin
                        rd_col = (state_reg == E_CRD1) ? one_c : '0;
                        rd_row = (state_reg == E_CRD1) ? '0 : one_c;
                        wr_col = '0;      wr_row = '0;
                    end
                    2'd1: begin
                        rd_col = (state_reg == E_CRD1) ? one_c : '0;
                        rd_row = (state_reg == E_CRD1) ? np1 : n_reg;
                        wr_col = '0;      wr_row = np1;
                    end
                    2'd2: begin
                        rd_col = (state_reg == E_CRD1) ? n_reg : np1;
                        rd_row = (state_reg == E_CRD1) ? '0 : one_c;
                        wr_col = np1;     wr_row = '0;
                    end
                    2'd3: begin
                        rd_col = (state_reg == E_CRD1) ? n_reg : np1;
                        rd_row = (state_reg == E_CRD1) ? np1 : n_reg;
                        wr_col = np1;     wr_row = np1;
                    end
                endcase
                res_we    = (state_reg == E_CWR);
                res_wdata = pair_sum[32:1];
            end
            default: begin
                res_we = 1'b0;
            end
        endcase
    end

    assign res_raddr = cell_addr(rd_col, rd_row);
    assign res_waddr = cell_addr(wr_col, wr_row);
    assign src_raddr = cell_addr(i_reg, j_reg);

    gsd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == E_NUM),
        .dividend (div_dividend),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_q),
        .overflow (div_ovf)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            sat_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                E_IDLE: begin
                    if (start) begin
                        n_reg     <= n_w;
                        sat_reg   <= 1'b0;
                        state_reg <= E_A1;
                    end
                end
                E_A1: begin
                    ab_reg    <= cfg.time_step * cfg.diffusion_rate;
                    state_reg <= E_A2;
                end
                E_A2: begin
                    u_reg     <= ab_reg[61:16] * n_reg;
                    state_reg <= E_A3;
                end
                E_A3: begin
                    if (u_reg > UW'(A_MAX)) begin
                        sat_reg <= 1'b1;
                        p_reg   <= PW'(A_MAX);
                    end else begin
                        p_reg <= u_reg[28:0] * n_reg;
                    end
                    state_reg <= E_A4;
                end
                E_A4: begin
                    if (p_reg > PW'(A_MAX)) begin
                        sat_reg <= 1'b1;
                        a_reg   <= A_MAX;
                    end else begin
                        a_reg <= p_reg[28:0];
                    end
                    i_reg     <= one_c;
                    j_reg     <= one_c;
                    k_reg     <= '0;
                    cnt_reg   <= 3'd0;
                    sum_reg   <= '0;
                    state_reg <= E_RD;
                end
                E_RD: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg != 3'd0) begin
                        sum_reg <= sum_reg + {{2{res_rdata[31]}}, res_rdata};
                    end
                    if (cnt_reg == 3'd1) begin
                        src_reg <= src_rdata;
                    end
                    if (cnt_reg == 3'd4) begin
                        state_reg <= E_MUL;
                    end
                end
                E_MUL: begin
                    prod_reg  <= a_s * sum_reg;
                    state_reg <= E_NUM;
                end
                E_NUM: begin
                    neg_reg   <= num[63];
                    state_reg <= E_DIV;
                end
                E_DIV: begin
                    if (div_done) begin
                        if (wr_sat) begin
                            sat_reg <= 1'b1;
                        end
                        cnt_reg   <= 3'd0;
                        sum_reg   <= '0;
                        state_reg <= ((j_reg == n_reg) && (i_reg == n_reg)
                                      && (k_reg == KW'(SWEEPS - 1))) ? E_BRD : E_RD;
                        if (j_reg == n_reg) begin
                            j_reg <= one_c;
                            if (i_reg == n_reg) begin
                                i_reg <= one_c;
                                if (k_reg == KW'(SWEEPS - 1)) begin
                                    side_reg <= 2'd0;
                                end else begin
                                    k_reg <= k_reg + KW'(1);
                                end
                            end else begin
                                i_reg <= i_reg + one_c;
                            end
                        end else begin
                            j_reg <= j_reg + one_c;
                        end
                    end
                end
                E_BRD: begin
                    state_reg <= E_BWR;
                end
                E_BWR: begin
                    if (edge_sat) begin
                        sat_reg <= 1'b1;
                    end
                    side_reg  <= side_reg + 2'd1;
                    state_reg <= ((side_reg == 2'd3) && (i_reg == n_reg)) ? E_CRD1 : E_BRD;
                    if ((side_reg == 2'd3) && (i_reg != n_reg)) begin
                        i_reg <= i_reg + one_c;
                    end
                end
                E_CRD1: begin
                    state_reg <= E_CRD2;
                end
                E_CRD2: begin
                    hold_reg  <= res_rdata;
                    state_reg <= E_CWR;
                end
                E_CWR: begin
                    side_reg  <= side_reg + 2'd1;
                    state_reg <= (side_reg == 2'd3) ? E_DONE : E_CRD1;
                end
                E_DONE: begin
                    state_reg <= E_IDLE;
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != E_IDLE);
    assign done = (state_reg == E_DONE);
    assign sat  = sat_reg;

endmodule

>>> sv/gauss_seidel_diffusion_grid.sv
// Top level of the Gauss-Seidel diffusion grid: command handshake, configuration
// registers, the two grid memories and the result register.
// Depends on gsd_pkg, gsd_ram and gsd_engine.
//
//  Channel  Direction  Payload
//  s_       in         tuser: command; tdata: col, row, source, guess
//  m_       out        tuser: reply kind; tdata: cell value, saturated
//  cfg_     in         register index and write data, no read-back
//
// A read transaction waits on the registered memory read port before its reply is
// loaded; a write does not. Each cell of a run needs five memory reads, a multiply
// and a 33-step divider pass. Reset clears control state only; the grids hold
// nothing defined until written. A stalled result holds the next transaction back
// only when the result register is full.
module gauss_seidel_diffusion_grid #(
    parameter int MAX_SIDE = gsd_pkg::DEF_MAX_SIDE,
    parameter int SWEEPS   = gsd_pkg::DEF_SWEEPS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // col[6:0], row[13:7], source[45:14], guess[77:46], zero pad
    input  logic [gsd_pkg::S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cell_value[31:0], saturated[32], zero pad
    output logic [gsd_pkg::M_TDATA_W-1:0] m_tdata,
    // reply_kind[1:0]
    output logic [1:0]                    m_tuser,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [30:0]                   cfg_wdata
);
    import gsd_pkg::*;

    localparam int SPAN  = MAX_SIDE + 2;
    localparam int CELLS = SPAN * SPAN;
    localparam int CW    = $clog2(SPAN);
    localparam int XW    = (CW > 7) ? CW : 7;
    localparam int AW    = $clog2(CELLS);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_READ = 2'd1;
    localparam logic [1:0] T_RUN  = 2'd2;

    cfg_t        cfg_reg;
    logic [1:0]  state_reg;
    logic        rd_inside_reg;
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [31:0] m_value_reg;
    logic        m_sat_reg;

    logic [1:0]    cmd;
    logic [XW-1:0] col_x;
    logic [XW-1:0] row_x;
    logic          in_grid;
    logic [AW-1:0] cmd_addr;
    logic          accept;
    logic          top_we;
    logic          out_load;
    logic [1:0]    out_kind;
    logic [31:0]   out_value;

    logic          eng_busy;
    logic          eng_done;
    logic          eng_sat;
    logic          eng_res_we;
    logic [AW-1:0] eng_res_waddr;
    logic [31:0]   eng_res_wdata;
    logic [AW-1:0] eng_res_raddr;
    logic [AW-1:0] eng_src_raddr;
    logic [31:0]   res_rdata;
    logic [31:0]   src_rdata;

    assign cmd      = s_tuser;
    assign col_x    = XW'(s_tdata[6:0]);
    assign row_x    = XW'(s_tdata[13:7]);
    assign in_grid  = (col_x <= XW'(SPAN - 1)) && (row_x <= XW'(SPAN - 1));
    assign cmd_addr = AW'(col_x[CW-1:0]) * AW'(SPAN) + AW'(row_x[CW-1:0]);
    assign s_tready = (state_reg == T_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign top_we   = accept && (cmd == CMD_WRITE) && in_grid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_size      <= RST_GRID_SIZE;
            cfg_reg.boundary_mode  <= 2'd0;
            cfg_reg.diffusion_rate <= 31'd0;
            cfg_reg.time_step      <= 31'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRID_SIZE:      cfg_reg.grid_size      <= cfg_wdata[6:0];
                REG_BOUNDARY_MODE:  cfg_reg.boundary_mode  <= cfg_wdata[1:0];
                REG_DIFFUSION_RATE: cfg_reg.diffusion_rate <= cfg_wdata;
                REG_TIME_STEP:      cfg_reg.time_step      <= cfg_wdata;
            endcase
        end
    end

    gsd_ram #(.DEPTH(CELLS), .AW(AW)) u_src_ram (
        .aclk  (aclk),
        .we    (top_we),
        .waddr (cmd_addr),
        .wdata (s_tdata[45:14]),
        .raddr (eng_src_raddr),
        .rdata (src_rdata)
    );

    gsd_ram #(.DEPTH(CELLS), .AW(AW)) u_res_ram (
        .aclk  (aclk),
        .we    (eng_busy ? eng_res_we : top_we),
        .waddr (eng_busy ? eng_res_waddr : cmd_addr),
        .wdata (eng_busy ? eng_res_wdata : s_tdata[77:46]),
        .raddr (eng_busy ? eng_res_raddr : cmd_addr),
        .rdata (res_rdata)
    );

    gsd_engine #(.MAX_SIDE(MAX_SIDE), .SWEEPS(SWEEPS), .AW(AW)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept && (cmd == CMD_RUN)),
        .cfg       (cfg_reg),
        .busy      (eng_busy),
        .done      (eng_done),
        .sat       (eng_sat),
        .res_we    (eng_res_we),
        .res_waddr (eng_res_waddr),
        .res_wdata (eng_res_wdata),
        .res_raddr (eng_res_raddr),
        .res_rdata (res_rdata),
        .src_raddr (eng_src_raddr),
        .src_rdata (src_rdata)
    );

    always_comb begin
        out_load  = 1'b0;
        out_kind  = REPLY_ACK;
        out_value = 32'd0;
        unique case (state_reg)
            T_IDLE: begin
                out_load = accept && (cmd != CMD_RUN) && (cmd != CMD_READ);
            end
            T_READ: begin
                out_load  = 1'b1;
                out_kind  = REPLY_DATA;
                out_value = rd_inside_reg ? res_rdata : 32'd0;
            end
            T_RUN: begin
                out_load = eng_done;
                out_kind = REPLY_RUN;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_kind_reg  <= out_kind;
                m_value_reg <= out_value;
                m_sat_reg   <= eng_sat;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        unique case (cmd)
                            CMD_RUN:  state_reg <= T_RUN;
                            CMD_READ: begin
                                state_reg     <= T_READ;
                                rd_inside_reg <= in_grid;
                            end
                            CMD_WRITE, CMD_NOP: state_reg <= T_IDLE;
                        endcase
                    end
                end
                T_READ: state_reg <= T_IDLE;
                T_RUN: begin
                    if (eng_done) begin
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {7'd0, m_sat_reg, m_value_reg};

endmodule

>>> tb/gsd_checker.sv
`timescale 1ns / 1ps
// Checker for the Gauss-Seidel diffusion grid: watches the command, reply and
// register ports, predicts every reply and compares it. Depends on gsd_pkg.
module gsd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    import gsd_pkg::*;

    localparam int SPAN = DEF_MAX_SIDE + 2;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        sat;
    } reply_t;

    reply_t reply_q[$];
    logic signed [31:0] src_mem [0:SPAN*SPAN-1];
    logic signed [31:0] res_mem [0:SPAN*SPAN-1];
    logic        sat_seen;
    cfg_t        regs;

    initial begin
        fail_count = 0;
        pending = 0;
        sat_seen = 1'b0;
        regs.grid_size = RST_GRID_SIZE;
        regs.boundary_mode = 2'd0;
        regs.diffusion_rate = '0;
        regs.time_step = '0;
        for (int c = 0; c < SPAN*SPAN; c++) begin
            src_mem[c] = '0;
            res_mem[c] = '0;
        end
    end

    function automatic logic signed [31:0] clamp_q(longint v);
        if (v > longint'(32'sh7FFF_FFFF)) begin
            sat_seen = 1'b1;
            return Q_MAX;
        end
        if (v < -longint'(64'sh8000_0000)) begin
            sat_seen = 1'b1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] edge_q(logic signed [31:0] v, logic neg);
        return neg ? clamp_q(-longint'(v)) : v;
    endfunction

    function automatic logic signed [31:0] mean_floor(logic signed [31:0] x,
                                                     logic signed [31:0] y);
        longint s;
        s = longint'(x) + longint'(y);
        s = s >>> 1;
        return s[31:0];
    endfunction

    function automatic int at(int c, int r);
        return c * SPAN + r;
    endfunction

    function automatic void diffuse_grid();
        int n;
        longint unsigned prod;
        longint unsigned mag;
        longint unsigned den;
        longint amul, sum, num, q;
        logic neg_c, neg_r;
        n = int'(regs.grid_size);
        if (n < 1) n = 1;
        if (n > DEF_MAX_SIDE) n = DEF_MAX_SIDE;
        neg_c = regs.boundary_mode == BND_NEG_COL;
        neg_r = regs.boundary_mode == BND_NEG_ROW;
        sat_seen = 1'b0;
        prod = (longint'(regs.time_step) * longint'(regs.diffusion_rate)) >> 16;
        prod = prod * n * n;
        if (prod > longint'(A_MAX)) begin
            sat_seen = 1'b1;
            prod = longint'(A_MAX);
        end
        amul = longint'(prod);
        den = 65536 + 4 * prod;
        for (int k = 0; k < DEF_SWEEPS; k++) begin
            for (int i = 1; i <= n; i++) begin
                for (int j = 1; j <= n; j++) begin
                    sum = longint'(res_mem[at(i-1, j)]) + longint'(res_mem[at(i+1, j)])
                        + longint'(res_mem[at(i, j-1)]) + longint'(res_mem[at(i, j+1)]);
                    num = longint'(src_mem[at(i, j)]) * 65536 + amul * sum;
                    mag = num < 0 ? longint'(-num) : longint'(num);
                    q = longint'((mag + den / 2) / den);
                    res_mem[at(i, j)] = clamp_q(num < 0 ? -q : q);
                end
            end
        end
        for (int i = 1; i <= n; i++) begin
            res_mem[at(0, i)]   = edge_q(res_mem[at(1, i)], neg_c);
            res_mem[at(n+1, i)] = edge_q(res_mem[at(n, i)], neg_c);
            res_mem[at(i, 0)]   = edge_q(res_mem[at(i, 1)], neg_r);
            res_mem[at(i, n+1)] = edge_q(res_mem[at(i, n)], neg_r);
        end
        res_mem[at(0, 0)]     = mean_floor(res_mem[at(1, 0)], res_mem[at(0, 1)]);
        res_mem[at(0, n+1)]   = mean_floor(res_mem[at(1, n+1)], res_mem[at(0, n)]);
        res_mem[at(n+1, 0)]   = mean_floor(res_mem[at(n, 0)], res_mem[at(n+1, 1)]);
        res_mem[at(n+1, n+1)] = mean_floor(res_mem[at(n, n+1)], res_mem[at(n+1, n)]);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: reply %s mismatch: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        reply_t r;
        reply_t w;
        logic [6:0] col, row;
        logic in_grid;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GRID_SIZE:      regs.grid_size = cfg_wdata[6:0];
                    REG_BOUNDARY_MODE:  regs.boundary_mode = cfg_wdata[1:0];
                    REG_DIFFUSION_RATE: regs.diffusion_rate = cfg_wdata;
                    REG_TIME_STEP:      regs.time_step = cfg_wdata;
                endcase
            end
            if (s_tvalid && s_tready) begin
                col = s_tdata[6:0];
                row = s_tdata[13:7];
                in_grid = col <= DEF_MAX_SIDE + 1 && row <= DEF_MAX_SIDE + 1;
                r.kind = REPLY_ACK;
                r.value = '0;
                case (s_tuser)
                    CMD_WRITE: begin
                        if (in_grid) begin
                            src_mem[at(col, row)] = s_tdata[45:14];
                            res_mem[at(col, row)] = s_tdata[77:46];
                        end
                    end
                    CMD_RUN: begin
                        diffuse_grid();
                        r.kind = REPLY_RUN;
                    end
                    CMD_READ: begin
                        r.kind = REPLY_DATA;
                        if (in_grid) r.value = res_mem[at(col, row)];
                    end
                    default: ;
                endcase
                r.sat = sat_seen;
                reply_q.push_back(r);
            end
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    report("unexpected", m_tdata[31:0], '0);
                end else begin
                    w = reply_q.pop_front();
                    if (m_tuser !== w.kind) report("kind", 32'(m_tuser), 32'(w.kind));
                    if (m_tdata[31:0] !== w.value) report("value", m_tdata[31:0], w.value);
                    if (m_tdata[32] !== w.sat) report("saturated", 32'(m_tdata[32]), 32'(w.sat));
                end
            end
            pending = reply_q.size();
        end
    end
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the Gauss-Seidel diffusion grid testbench: clock, reset, commands,
// register writes and the verdict. Depends on gsd_pkg, gsd_checker and the block.
module tb;
    import gsd_pkg::*;

    localparam int SPAN = DEF_MAX_SIDE + 2;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_wdata;
    int          fail_count;
    int          pending;

    bit written [0:SPAN*SPAN-1];
    int items;
    int tx_idle;
    int rx_idle;
    bit hold_req;
    int hold_cnt;

    gauss_seidel_diffusion_grid u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    gsd_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("gauss_seidel_diffusion_grid verification failed");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= $urandom_range(99) >= rx_idle;
            end
        end
    end

    task automatic send_item(logic [1:0] cmd, int col, int row,
                             logic [31:0] src, logic [31:0] guess);
        logic [6:0] c7;
        logic [6:0] r7;
        c7 = 7'(col);
        r7 = 7'(row);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, guess, src, r7, c7};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_WRITE && c7 <= SPAN - 1 && r7 <= SPAN - 1)
            written[c7 * SPAN + r7] = 1'b1;
        items++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[30:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h3_FFFF) - 32'h2_0000;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(5))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(32'h3_0000);
        endcase
    endfunction

    task automatic fill_square(int n);
        for (int c = 0; c <= n + 1; c++)
            for (int r = 0; r <= n + 1; r++)
                if (!written[c * SPAN + r])
                    send_item(CMD_WRITE, c, r, pick_value(), pick_value());
    endtask

    initial begin
        int n;
        int g;
        int c;
        int r;
        int count;
        int phase;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_WRITE;
        cfg_we = 1'b0;
        cfg_index = REG_GRID_SIZE;
        cfg_wdata = '0;
        items = 0;
        tx_idle = 12;
        rx_idle = 47;
        hold_req = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Smallest grid, negated column edges, zero coefficient: the most negative
        // interior value saturates when it is negated onto the edge.
        set_reg(REG_GRID_SIZE, 1);
        set_reg(REG_BOUNDARY_MODE, 32'(BND_NEG_COL));
        set_reg(REG_DIFFUSION_RATE, '0);
        set_reg(REG_TIME_STEP, 32'h7FFF_FFFF);
        send_item(CMD_WRITE, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF);
        fill_square(1);
        send_item(CMD_WRITE, 127, 127, 32'h1234_5678, 32'h1234_5678);
        send_item(CMD_WRITE, 70, 0, 32'h1, 32'h1);
        send_item(CMD_NOP, 127, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_RUN, 0, 0, 0, 0);
        send_item(CMD_READ, 0, 0, 0, 0);
        send_item(CMD_READ, 0, 1, 0, 0);
        send_item(CMD_READ, 2, 2, 0, 0);
        send_item(CMD_READ, 1, 1, 0, 0);
        send_item(CMD_READ, 66, 3, 0, 0);
        send_item(CMD_READ, 3, 127, 0, 0);
        wait_idle();
        set_reg(REG_DIFFUSION_RATE, 32'h7FFF_FFFF);
        send_item(CMD_RUN, 0, 0, 0, 0);
        send_item(CMD_READ, 1, 2, 0, 0);

        phase = 0;
        while (items < 920) begin
            wait_idle();
            if (items < 330) begin
                tx_idle = 12;
                rx_idle = 47;
            end else if (items < 630) begin
                tx_idle = 47;
                rx_idle = 12;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case ($urandom_range(19))
                0: g = 0;
                1: g = 8;
                default: g = $urandom_range(1, 5);
            endcase
            n = g < 1 ? 1 : g;
            set_reg(REG_GRID_SIZE, g);
            set_reg(REG_BOUNDARY_MODE, $urandom_range(3));
            set_reg(REG_DIFFUSION_RATE, pick_coef());
            set_reg(REG_TIME_STEP, pick_coef());
            if (phase == 3) hold_req = 1'b1;
            fill_square(n);
            count = $urandom_range(10, 30);
            repeat (count) begin
                c = $urandom_range(n + 1);
                r = $urandom_range(n + 1);
                case ($urandom_range(9))
                    0, 1, 2: send_item(CMD_WRITE, c, r, pick_value(), pick_value());
                    3: send_item(CMD_WRITE, $urandom_range(127), $urandom_range(127),
                                 pick_value(), pick_value());
                    4: send_item(CMD_RUN, $urandom, $urandom, $urandom, $urandom);
                    5: begin
                        c = $urandom_range(127);
                        r = $urandom_range(127);
                        if (c <= SPAN - 1 && r <= SPAN - 1 && !written[c * SPAN + r]) begin
                            c = SPAN + $urandom_range(127 - SPAN);
                        end
                        send_item(CMD_READ, c, r, $urandom, $urandom);
                    end
                    6: send_item(CMD_NOP, $urandom, $urandom, $urandom, $urandom);
                    default: send_item(CMD_READ, c, r, $urandom, $urandom);
                endcase
            end
            send_item(CMD_RUN, 0, 0, 0, 0);
            repeat ($urandom_range(3, 8))
                send_item(CMD_READ, $urandom_range(n + 1), $urandom_range(n + 1), 0, 0);
            phase++;
        end

        // Largest grid settings, exercised by loads and reads only.
        wait_idle();
        set_reg(REG_GRID_SIZE, 127);
        set_reg(REG_GRID_SIZE, 64);
        send_item(CMD_WRITE, 65, 65, pick_value(), pick_value());
        send_item(CMD_WRITE, 64, 0, pick_value(), pick_value());
        send_item(CMD_READ, 65, 65, 0, 0);
        send_item(CMD_READ, 64, 0, 0, 0);
        send_item(CMD_READ, 0, 0, 0, 0);

        wait_idle();
        repeat (50) @(negedge aclk);
        if (fail_count == 0) begin
            $display("gauss_seidel_diffusion_grid verification clean");
        end else begin
            $display("gauss_seidel_diffusion_grid verification failed");
        end
        $finish;
    end
endmodule
